### rtl/ema_hysteresis_level_detector_defines.svh
// Assertion macros for the EMA hysteresis level detector.
`ifndef EMA_HYSTERESIS_LEVEL_DETECTOR_DEFINES_SVH
`define EMA_HYSTERESIS_LEVEL_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define EHLD_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define EHLD_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/ehld_pkg.sv
// Shared types and constants for the EMA hysteresis level detector.
package ehld_pkg;

  localparam int SampleW = 16;
  localparam int LevelW  = 12;
  localparam int WarmW   = 8;
  localparam int ActW    = 2;
  localparam int CfgIdxW = 2;

  localparam logic [LevelW-1:0] EnterReset = LevelW'(3100);
  localparam logic [LevelW-1:0] ExitReset  = LevelW'(3400);
  localparam logic [WarmW-1:0]  WarmReset  = WarmW'(10);

  localparam logic [ActW-1:0] ActSample      = 2'd0;
  localparam logic [ActW-1:0] ActRemoteSet   = 2'd1;
  localparam logic [ActW-1:0] ActPulseFinish = 2'd2;

  localparam logic [CfgIdxW-1:0] RegEnter  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegExit   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegWarmup = 2'd2;

  typedef struct packed {
    logic              is_on;
    logic              state_changed;
    logic              sync_request;
    logic              warmup_done;
    logic              sample_invalid;
    logic [LevelW-1:0] average;
    logic              pulse_active;
    logic              pulse_start;
  } result_t;

endpackage

### rtl/ema_hysteresis_level_detector.sv
// EMA level detector with hysteresis decision and remote override.
//
//   channel  handshake            payload
//   in       in_valid/in_ready    action, raw_sample, target_on
//   out      out_valid/out_ready  is_on .. pulse_start (one result per item)
//   cfg      cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// One item per cycle sustained while the output is not stalled; the path is
// the input register, then the state update and result register. The
// average/decision loop closes through the state registers.
// Synchronous reset clears state, thresholds to defaults, both stages empty.
// A stalled output holds the input stage; the input stage still takes an
// item while it is empty.
`include "ema_hysteresis_level_detector_defines.svh"

module ema_hysteresis_level_detector import ehld_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ActW-1:0]      action,
  input  logic signed [SampleW-1:0] raw_sample,
  input  logic                 target_on,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 is_on,
  output logic                 state_changed,
  output logic                 sync_request,
  output logic                 warmup_done,
  output logic                 sample_invalid,
  output logic [LevelW-1:0]    average,
  output logic                 pulse_active,
  output logic                 pulse_start,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CfgIdxW-1:0]   cfg_index,
  input  logic [LevelW-1:0]    cfg_data
);

  // configuration
  logic [LevelW-1:0] enter_thr;
  logic [LevelW-1:0] exit_thr;
  logic [WarmW-1:0]  warm_len;

  // input stage
  logic               s1_valid;
  logic [ActW-1:0]    s1_action;
  logic [SampleW-1:0] s1_raw;
  logic               s1_target;

  // detector state
  logic [LevelW-1:0] avg;
  logic              loaded;
  logic [WarmW-1:0]  warm_cnt;
  logic              decided;
  logic              pulsing;

  result_t res;
  logic    advance;

  logic [LevelW-1:0] avg_next;
  logic              loaded_next;
  logic [WarmW-1:0]  warm_cnt_next;
  logic              decided_next;
  logic              pulsing_next;
  result_t           res_next;

  logic              sample_ok;
  logic [LevelW+1:0] blend;

  assign cfg_ready = 1'b1;
  assign advance   = !out_valid || out_ready;
  assign in_ready  = !s1_valid || advance;

  // sign bit or anything above 4095 sets an upper bit
  assign sample_ok = (s1_raw[SampleW-1:LevelW] == '0);
  assign blend     = {2'b00, avg} + {1'b0, avg, 1'b0} + {2'b00, s1_raw[LevelW-1:0]};

  always_comb begin
    avg_next      = avg;
    loaded_next   = loaded;
    warm_cnt_next = warm_cnt;
    decided_next  = decided;
    pulsing_next  = pulsing;
    res_next      = '0;
    case (s1_action)
      ActSample: begin
        if (!sample_ok) begin
          res_next.sample_invalid = 1'b1;
        end else begin
          avg_next    = loaded ? blend[LevelW+1:2] : s1_raw[LevelW-1:0];
          loaded_next = 1'b1;
          if (warm_cnt < warm_len) begin
            warm_cnt_next = warm_cnt + WarmW'(1);
            if (warm_cnt_next == warm_len) begin
              decided_next         = (avg_next <= enter_thr);
              res_next.warmup_done = 1'b1;
            end
          end else begin
            if (decided) begin
              decided_next = !(avg_next > exit_thr);
            end else begin
              decided_next = (avg_next <= enter_thr);
            end
            res_next.state_changed = (decided_next != decided);
            res_next.sync_request  = (decided_next != decided) && !pulsing;
          end
        end
      end
      ActRemoteSet: begin
        pulsing_next         = 1'b1;
        decided_next         = s1_target;
        res_next.pulse_start = 1'b1;
      end
      ActPulseFinish: begin
        pulsing_next = 1'b0;
      end
      default: begin
      end
    endcase
    res_next.is_on        = decided_next;
    res_next.average      = avg_next;
    res_next.pulse_active = pulsing_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enter_thr <= EnterReset;
      exit_thr  <= ExitReset;
      warm_len  <= WarmReset;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        RegEnter:  enter_thr <= cfg_data;
        RegExit:   exit_thr  <= cfg_data;
        RegWarmup: warm_len  <= cfg_data[WarmW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_action <= action;
      s1_raw    <= raw_sample;
      s1_target <= target_on;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      avg       <= '0;
      loaded    <= 1'b0;
      warm_cnt  <= '0;
      decided   <= 1'b0;
      pulsing   <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        avg      <= avg_next;
        loaded   <= loaded_next;
        warm_cnt <= warm_cnt_next;
        decided  <= decided_next;
        pulsing  <= pulsing_next;
      end
    end
    if (advance && s1_valid) begin
      res <= res_next;
    end
  end

  assign is_on          = res.is_on;
  assign state_changed  = res.state_changed;
  assign sync_request   = res.sync_request;
  assign warmup_done    = res.warmup_done;
  assign sample_invalid = res.sample_invalid;
  assign average        = res.average;
  assign pulse_active   = res.pulse_active;
  assign pulse_start    = res.pulse_start;

  `EHLD_ASSERT_NOW(a_sync_needs_change, clk, rst,
                   out_valid && sync_request, state_changed,
                   "sync_request without state_changed")
  `EHLD_ASSERT_NOW(a_invalid_no_events, clk, rst,
                   out_valid && sample_invalid,
                   !state_changed && !warmup_done && !pulse_start,
                   "event flag on rejected sample")
  `EHLD_ASSERT_NOW(a_result_tracks_state, clk, rst, out_valid,
                   is_on == decided && pulse_active == pulsing && average == avg,
                   "result disagrees with detector state")
  `EHLD_ASSERT_NEXT(a_stage_holds, clk, rst, s1_valid && !advance, s1_valid,
                    "input stage dropped while stalled")

endmodule
